// ===== hw/rtl/tvs_pkg.sv =====
// Shared types, codes and width helpers for the trilinear volume sampler.
// No dependencies; the other files, tvs_ram apart, refer to this package by scoped names.
`default_nettype none
package tvs_pkg;

	localparam int MAX_SIDE_DEF  = 32;
	localparam int FRAC_BITS_DEF = 8;

	localparam int VAL_W     = 16;
	localparam int COORD_W   = 16;
	localparam int WIDX_W    = 5;
	localparam int SIZE_W    = 6;
	localparam int MODE_W    = 2;
	localparam int CFG_IDX_W = 2;
	localparam int LIN_W     = 3 * SIZE_W;
	localparam int SIZE_RST  = 32;

	localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_TRI   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_NEAR  = 2'd2;
	localparam logic [MODE_W-1:0] MODE_NONE  = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 2'd2;

	typedef logic [SIZE_W-1:0] size_t;

	typedef struct packed {
		size_t x;
		size_t y;
		size_t z;
	} dims_t;

	// signed width of an integer voxel coordinate, neighbor offset included
	function automatic int coord_int_w(int frac_bits);
		return (18 - frac_bits > 7) ? (18 - frac_bits) : 7;
	endfunction

	function automatic int addr_w(int side);
		return $clog2(side * side * side);
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/tvs_ram.sv =====
// Single-port voxel memory, one access a cycle, registered read data.
// Depends on nothing but its parameters.
`default_nettype none
module tvs_ram #(
	parameter int DEPTH = 32768,
	parameter int AW    = 15,
	parameter int DW    = 16
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] addr,
	input  wire logic [DW-1:0] wdata,
	output logic      [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule
`default_nettype wire

// ===== hw/rtl/tvs_addr.sv =====
// Two-stage linear address generator: x + size_x*(y + size_y*z), with bounds check.
// Depends on tvs_pkg.
`default_nettype none
module tvs_addr #(
	parameter int MAX_SIDE  = tvs_pkg::MAX_SIDE_DEF,
	parameter int FRAC_BITS = tvs_pkg::FRAC_BITS_DEF,
	localparam int KW = tvs_pkg::coord_int_w(FRAC_BITS),
	localparam int AW = tvs_pkg::addr_w(MAX_SIDE)
) (
	input  wire logic                 clk,
	input  wire tvs_pkg::dims_t       eff,
	input  wire logic signed [KW-1:0] x,
	input  wire logic signed [KW-1:0] y,
	input  wire logic signed [KW-1:0] z,
	output logic             [AW-1:0] addr,
	output logic                      inb
);

	localparam int SW = tvs_pkg::SIZE_W;

	logic          in_x, in_y, in_z;
	logic [2*SW-1:0] yz;
	logic [SW-1:0]   x_s1;
	logic [2*SW-1:0] t1_s1;
	logic            inb_s1;
	logic [tvs_pkg::LIN_W-1:0] lin;

	always_comb begin
		in_x = !x[KW-1] && (x[KW-2:0] < (KW-1)'(eff.x));
		in_y = !y[KW-1] && (y[KW-2:0] < (KW-1)'(eff.y));
		in_z = !z[KW-1] && (z[KW-2:0] < (KW-1)'(eff.z));
		yz   = (2*SW)'(eff.y) * (2*SW)'(z[SW-1:0]) + (2*SW)'(y[SW-1:0]);
		lin  = tvs_pkg::LIN_W'(eff.x) * tvs_pkg::LIN_W'(t1_s1) + tvs_pkg::LIN_W'(x_s1);
	end

	always_ff @(posedge clk) begin
		x_s1   <= x[SW-1:0];
		t1_s1  <= yz;
		inb_s1 <= in_x && in_y && in_z;
		addr   <= AW'(lin);
		inb    <= inb_s1;
	end

endmodule
`default_nettype wire

// ===== hw/rtl/tvs_blend.sv =====
// Two-stage linear blend (a*(1-f) + b*f) >> F, truncated toward zero, saturated.
// Depends on tvs_pkg.
`default_nettype none
module tvs_blend #(
	parameter int FRAC_BITS = tvs_pkg::FRAC_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              go,
	input  wire logic signed [tvs_pkg::VAL_W-1:0]  a,
	input  wire logic signed [tvs_pkg::VAL_W-1:0]  b,
	input  wire logic signed [FRAC_BITS:0]         f,
	output logic signed      [tvs_pkg::VAL_W-1:0]  res,
	output logic                                   res_vld
);

	localparam int VW  = tvs_pkg::VAL_W;
	localparam int PW  = VW + FRAC_BITS + 2;
	localparam int SW2 = PW + 1;
	localparam logic signed [FRAC_BITS+1:0] ONE  = (FRAC_BITS+2)'(2**FRAC_BITS);
	localparam logic signed [SW2-1:0]       RND  = SW2'(2**FRAC_BITS - 1);
	localparam logic signed [SW2-1:0]       ZERO = '0;
	localparam logic signed [SW2-1:0]       VMAX = SW2'(2**(VW-1) - 1);
	localparam logic signed [SW2-1:0]       VMIN = ~VMAX;

	logic signed [FRAC_BITS+1:0] w0;
	logic signed [PW-1:0]        p0_s1, p1_s1;
	logic                        vld_s1;
	logic signed [SW2-1:0]       sum, q;

	always_comb begin
		w0  = ONE - {f[FRAC_BITS], f};
		sum = SW2'(p0_s1) + SW2'(p1_s1);
		q   = (sum + (sum[SW2-1] ? RND : ZERO)) >>> FRAC_BITS;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			res_vld <= 1'b0;
		end else begin
			vld_s1  <= go;
			res_vld <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			p0_s1 <= PW'(a) * PW'(w0);
			p1_s1 <= PW'(b) * PW'(f);
		end
		if (vld_s1) begin
			if (q > VMAX) begin
				res <= VMAX[VW-1:0];
			end else if (q < VMIN) begin
				res <= VMIN[VW-1:0];
			end else begin
				res <= q[VW-1:0];
			end
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/trilinear_volume_sampler.sv =====
// Trilinear volume sampler: takes write, nearest and trilinear items, one at a time.
// Nearest and trilinear items each give one out_valid beat; writes give no beat.
// Trilinear time is set by the single-port voxel RAM (one neighbor read a cycle)
// feeding a shared two-stage blend unit; one item is in work at a time.
// Reset clears control and sets all sizes to 32; the voxel RAM is not cleared.
// Depends on tvs_pkg, tvs_addr, tvs_ram, tvs_blend.
`default_nettype none
module trilinear_volume_sampler #(
	parameter int MAX_SIDE  = tvs_pkg::MAX_SIDE_DEF,
	parameter int FRAC_BITS = tvs_pkg::FRAC_BITS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_write,
	input  wire logic        [tvs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic        [tvs_pkg::SIZE_W-1:0]    cfg_data,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic        [tvs_pkg::MODE_W-1:0]    mode,
	input  wire logic        [tvs_pkg::WIDX_W-1:0]    write_x,
	input  wire logic        [tvs_pkg::WIDX_W-1:0]    write_y,
	input  wire logic        [tvs_pkg::WIDX_W-1:0]    write_z,
	input  wire logic signed [tvs_pkg::VAL_W-1:0]     write_value,
	input  wire logic signed [tvs_pkg::COORD_W-1:0]   coord_x,
	input  wire logic signed [tvs_pkg::COORD_W-1:0]   coord_y,
	input  wire logic signed [tvs_pkg::COORD_W-1:0]   coord_z,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic signed      [tvs_pkg::VAL_W-1:0]     sample_value
);

	localparam int KW    = tvs_pkg::coord_int_w(FRAC_BITS);
	localparam int AW    = tvs_pkg::addr_w(MAX_SIDE);
	localparam int DEPTH = MAX_SIDE * MAX_SIDE * MAX_SIDE;
	localparam int VW    = tvs_pkg::VAL_W;
	localparam int SW    = tvs_pkg::SIZE_W;
	localparam int CW    = tvs_pkg::COORD_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_BUSY = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	// step numbers; neighbor n enters the address pipe at step n, data at RD_LAT+n
	localparam logic [4:0] WR_STEP   = 5'd2;
	localparam logic [4:0] RD_LAT    = 5'd3;
	localparam logic [4:0] NEAR_STEP = RD_LAT;
	localparam logic [4:0] EV0       = 5'd3;
	localparam logic [4:0] EV1       = 5'd5;
	localparam logic [4:0] EV2       = 5'd7;
	localparam logic [4:0] EV3       = 5'd9;
	localparam logic [4:0] XGO0      = 5'd4;
	localparam logic [4:0] XGO1      = 5'd6;
	localparam logic [4:0] XGO2      = 5'd8;
	localparam logic [4:0] XGO3      = 5'd10;
	localparam logic [4:0] HOLD0     = 5'd6;
	localparam logic [4:0] HOLD1     = 5'd10;
	localparam logic [4:0] YGO0      = 5'd9;
	localparam logic [4:0] C0_CAP    = 5'd11;
	localparam logic [4:0] YGO1      = 5'd12;
	localparam logic [4:0] ZGO       = 5'd14;
	localparam logic [4:0] TRI_STEP  = 5'd16;

	function automatic tvs_pkg::size_t clamp_size(tvs_pkg::size_t s);
		return (9'(s) > 9'(MAX_SIDE)) ? SW'(MAX_SIDE) : s;
	endfunction

	function automatic logic signed [17:0] tz_int(logic signed [CW-1:0] c);
		logic signed [17:0] ce, bias;
		ce   = 18'(c);
		bias = c[CW-1] ? 18'(2**FRAC_BITS - 1) : 18'(0);
		return (ce + bias) >>> FRAC_BITS;
	endfunction

	function automatic logic signed [FRAC_BITS:0] tz_frac(logic signed [CW-1:0] c);
		logic signed [17:0] ce, u, fr;
		ce = 18'(c);
		u  = tz_int(c);
		fr = ce - (u <<< FRAC_BITS);
		return fr[FRAC_BITS:0];
	endfunction

	function automatic logic signed [KW-1:0] near_int(logic signed [CW-1:0] c);
		logic signed [17:0] ce, m, n;
		ce = 18'(c);
		m  = c[CW-1] ? -ce : ce;
		n  = (m + 18'(2**(FRAC_BITS-1))) >>> FRAC_BITS;
		return c[CW-1] ? KW'(-n) : KW'(n);
	endfunction

	tvs_pkg::dims_t size_q, eff;
	logic [1:0]     state_q;
	logic [4:0]     cnt_q, last_step;
	logic [tvs_pkg::MODE_W-1:0] mode_q;
	logic           in_acc, out_load;

	logic signed [KW-1:0]      bx_q, by_q, bz_q, ag_x, ag_y, ag_z;
	logic signed [FRAC_BITS:0] fx_q, fy_q, fz_q, bl_f;
	logic signed [VW-1:0]      wval_q, val, ev_q, hold_q, c0_q, fin_q, sample_q;
	logic signed [VW-1:0]      bl_a, bl_b, bl_res;
	logic                      bl_go, bl_vld;
	logic [AW-1:0]             ram_addr;
	logic                      ram_inb, rd_inb_q, ram_we, out_valid_q;
	logic [VW-1:0]             ram_rdata;

	assign eff.x = clamp_size(size_q.x);
	assign eff.y = clamp_size(size_q.y);
	assign eff.z = clamp_size(size_q.z);

	assign in_stall     = (state_q != ST_IDLE);
	assign in_acc       = in_valid && !in_stall;
	assign out_valid    = out_valid_q;
	assign sample_value = sample_q;
	assign out_load     = (state_q == ST_FIN) && (!out_valid_q || !out_stall);

	assign ag_x = bx_q + KW'(cnt_q[0]);
	assign ag_y = by_q + KW'(cnt_q[1]);
	assign ag_z = bz_q + KW'(cnt_q[2]);
	assign val  = rd_inb_q ? $signed(ram_rdata) : '0;

	assign ram_we = (state_q == ST_BUSY) && (mode_q == tvs_pkg::MODE_WRITE) &&
		(cnt_q == WR_STEP) && ram_inb;

	always_comb begin
		unique case (mode_q)
			tvs_pkg::MODE_WRITE: last_step = WR_STEP;
			tvs_pkg::MODE_TRI:   last_step = TRI_STEP;
			default:             last_step = NEAR_STEP;
		endcase
	end

	always_comb begin
		bl_go = 1'b0;
		bl_a  = ev_q;
		bl_b  = val;
		bl_f  = fx_q;
		if ((state_q == ST_BUSY) && (mode_q == tvs_pkg::MODE_TRI)) begin
			unique case (cnt_q)
				XGO0, XGO1, XGO2, XGO3: begin
					bl_go = 1'b1;
				end
				YGO0, YGO1: begin
					bl_go = 1'b1;
					bl_a  = hold_q;
					bl_b  = bl_res;
					bl_f  = fy_q;
				end
				ZGO: begin
					bl_go = 1'b1;
					bl_a  = c0_q;
					bl_b  = bl_res;
					bl_f  = fz_q;
				end
				default: begin
					bl_go = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q.x <= SW'(tvs_pkg::SIZE_RST);
			size_q.y <= SW'(tvs_pkg::SIZE_RST);
			size_q.z <= SW'(tvs_pkg::SIZE_RST);
		end else if (cfg_write) begin
			unique case (cfg_index)
				tvs_pkg::REG_SIZE_X: size_q.x <= cfg_data;
				tvs_pkg::REG_SIZE_Y: size_q.y <= cfg_data;
				tvs_pkg::REG_SIZE_Z: size_q.z <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			mode_q      <= tvs_pkg::MODE_NONE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						mode_q <= mode;
						cnt_q  <= '0;
						if (mode != tvs_pkg::MODE_NONE) begin
							state_q <= ST_BUSY;
						end
					end
				end
				ST_BUSY: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == last_step) begin
						state_q <= (mode_q == tvs_pkg::MODE_WRITE) ? ST_IDLE : ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_inb_q <= ram_inb;
		if (in_acc) begin
			wval_q <= write_value;
			fx_q   <= tz_frac(coord_x);
			fy_q   <= tz_frac(coord_y);
			fz_q   <= tz_frac(coord_z);
			unique case (mode)
				tvs_pkg::MODE_WRITE: begin
					bx_q <= KW'(write_x);
					by_q <= KW'(write_y);
					bz_q <= KW'(write_z);
				end
				tvs_pkg::MODE_TRI: begin
					bx_q <= KW'(tz_int(coord_x));
					by_q <= KW'(tz_int(coord_y));
					bz_q <= KW'(tz_int(coord_z));
				end
				default: begin
					bx_q <= near_int(coord_x);
					by_q <= near_int(coord_y);
					bz_q <= near_int(coord_z);
				end
			endcase
		end
		if (state_q == ST_BUSY) begin
			if (cnt_q == EV0 || cnt_q == EV1 || cnt_q == EV2 || cnt_q == EV3) begin
				ev_q <= val;
			end
			if (cnt_q == HOLD0 || cnt_q == HOLD1) begin
				hold_q <= bl_res;
			end
			if (cnt_q == C0_CAP) begin
				c0_q <= bl_res;
			end
			if (cnt_q == last_step) begin
				fin_q <= (mode_q == tvs_pkg::MODE_TRI) ?
					(bl_res[VW-1] ? '0 : bl_res) : val;
			end
		end
		if (out_load) begin
			sample_q <= fin_q;
		end
	end

	tvs_addr #(
		.MAX_SIDE (MAX_SIDE),
		.FRAC_BITS(FRAC_BITS)
	) u_addr (
		.clk (clk),
		.eff (eff),
		.x   (ag_x),
		.y   (ag_y),
		.z   (ag_z),
		.addr(ram_addr),
		.inb (ram_inb)
	);

	tvs_ram #(
		.DEPTH(DEPTH),
		.AW   (AW),
		.DW   (VW)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(wval_q),
		.rdata(ram_rdata)
	);

	tvs_blend #(
		.FRAC_BITS(FRAC_BITS)
	) u_blend (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (bl_go),
		.a      (bl_a),
		.b      (bl_b),
		.f      (bl_f),
		.res    (bl_res),
		.res_vld(bl_vld)
	);

	a_blend_tri_only: assert property (@(posedge clk) disable iff (!arst_n)
		bl_vld |-> (mode_q == tvs_pkg::MODE_TRI))
		else $error("blend result outside a trilinear item");

	a_tri_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && mode_q == tvs_pkg::MODE_TRI) |=> !sample_value[VW-1])
		else $error("negative trilinear result");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && mode != tvs_pkg::MODE_NONE) |=> (state_q == ST_BUSY && cnt_q == 5'd0))
		else $error("accepted item did not start");

	a_fin_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN) |->
		(mode_q == tvs_pkg::MODE_TRI || mode_q == tvs_pkg::MODE_NEAR))
		else $error("result pending for an item without result");

	a_we_mode: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (mode_q == tvs_pkg::MODE_WRITE && $past(state_q) == ST_BUSY))
		else $error("voxel RAM written outside a write item");

endmodule
`default_nettype wire
